@@ rtl/oal_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_pkg
// Shared types and codes of the ordered array list engine.
// ----------------------------------------------------------------------------
package oal_pkg;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_FIND   = 3'd2,
    OP_READ   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } st_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_DRAIN,
    S_FINISH
  } ctl_state_t;

  typedef struct packed {
    logic load;    // latch the request beat
    logic prime;   // set up walk bounds
    logic issue;   // read one entry and advance
    logic commit;  // update count, present result
  } cmd_t;

  typedef struct packed {
    logic walk_needed;
    logic walk_last;
    logic match;
    logic out_busy;
  } sts_t;

endpackage

@@ rtl/oal_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_req_if
// Request channel: operation, position and data word with valid/ready.
// ----------------------------------------------------------------------------
interface oal_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic [6:0]         position;
  logic signed [31:0] data_word;

  modport source (output valid, output operation, output position,
                  output data_word, input ready);
  modport sink   (input valid, input operation, input position,
                  input data_word, output ready);
endinterface

@@ rtl/oal_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_rsp_if
// Result channel: status, found position, read word, count, empty flag.
// ----------------------------------------------------------------------------
interface oal_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [6:0]         found_position;
  logic signed [31:0] read_word;
  logic [7:0]         entry_count;
  logic               is_empty;

  modport source (output valid, output status, output found_position,
                  output read_word, output entry_count, output is_empty,
                  input ready);
  modport sink   (input valid, input status, input found_position,
                  input read_word, input entry_count, input is_empty,
                  output ready);
endinterface

@@ rtl/oal_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_ctrl
// Sequencer: takes a request, walks the store, then commits the result.
// ----------------------------------------------------------------------------
module oal_ctrl
  import oal_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.prime = 1'b1;
        state_nxt = sts.walk_needed ? S_WALK : S_FINISH;
      end
      S_WALK: begin
        // stop the search on the first hit
        if (sts.match) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.issue = 1'b1;
          if (sts.walk_last) begin
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // hold until the previous result beat is taken
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/oal_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_dp
// Datapath: entry store, live count, walk index and result register.
// ----------------------------------------------------------------------------
module oal_dp
  import oal_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [2:0]         in_operation,
  input  logic [6:0]         in_position,
  input  logic signed [31:0] in_data_word,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [6:0]         out_found_position,
  output logic signed [31:0] out_read_word,
  output logic [7:0]         out_entry_count,
  output logic               out_is_empty
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 8) ? CW : 8;

  logic [31:0]   mem [CAPACITY];

  logic [2:0]    op_r;
  logic [6:0]    pos_r;
  logic [31:0]   word_r;
  logic [CW-1:0] count_r;
  logic [AW-1:0] idx_r;
  logic [AW-1:0] end_r;
  logic          pend_valid_r;
  logic [AW-1:0] pend_addr_r;
  logic [31:0]   rd_data_r;
  logic          hit_r;
  logic [AW-1:0] found_r;
  logic [31:0]   readv_r;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [6:0]    out_found_r;
  logic [31:0]   out_read_r;
  logic [7:0]    out_count_r;
  logic          out_empty_r;

  logic [XW-1:0] pos_x;
  logic [XW-1:0] count_x;
  logic [XW-1:0] start_x;
  logic [XW-1:0] end_x;
  logic [XW-1:0] cnt_nxt_x;
  logic [XW-1:0] found_x;
  st_t           err_code;
  st_t           st_nxt;
  logic          ok;
  logic          walk_needed;
  logic          match;
  logic          shift_we;
  logic          fin_we;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic [CW-1:0] count_nxt;

  assign pos_x   = XW'(pos_r);
  assign count_x = XW'(count_r);
  assign found_x = XW'(found_r);

  // request checks and walk bounds
  always_comb begin
    err_code    = ST_OK;
    walk_needed = 1'b0;
    start_x     = '0;
    end_x       = '0;
    case (op_r)
      OP_INSERT: begin
        if (count_r >= CW'(CAPACITY)) begin
          err_code = ST_FULL;
        end else if (pos_x > count_x) begin
          err_code = ST_RANGE;
        end
        walk_needed = (err_code == ST_OK) && (count_x > pos_x);
        start_x     = count_x - XW'(1);
        end_x       = pos_x;
      end
      OP_DELETE: begin
        if (pos_x >= count_x) begin
          err_code = ST_RANGE;
        end
        walk_needed = (err_code == ST_OK) && (count_x > pos_x + XW'(1));
        start_x     = pos_x + XW'(1);
        end_x       = count_x - XW'(1);
      end
      OP_FIND: begin
        walk_needed = (count_r != '0);
        end_x       = count_x - XW'(1);
      end
      OP_READ: begin
        if (pos_x >= count_x) begin
          err_code = ST_RANGE;
        end
        walk_needed = (err_code == ST_OK);
        start_x     = pos_x;
        end_x       = pos_x;
      end
      default: begin
        err_code = ST_OK;
      end
    endcase
  end

  assign ok    = (err_code == ST_OK);
  assign match = pend_valid_r && (op_r == OP_FIND) && (rd_data_r == word_r);

  assign sts.walk_needed = walk_needed;
  assign sts.walk_last   = (idx_r == end_r);
  assign sts.match       = match;
  assign sts.out_busy    = out_valid_r && !out_ready;

  // store write port: shift beats during the walk, new word at commit
  assign shift_we = pend_valid_r && ((op_r == OP_INSERT) || (op_r == OP_DELETE));
  assign fin_we   = cmd.commit && (op_r == OP_INSERT) && ok;
  assign wr_en    = shift_we || fin_we;
  assign wr_addr  = fin_we ? pos_x[AW-1:0] : pend_addr_r;
  assign wr_data  = fin_we ? word_r : rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.issue) begin
      rd_data_r <= mem[idx_r];
    end
  end

  always_comb begin
    count_nxt = count_r;
    st_nxt    = err_code;
    case (op_r)
      OP_INSERT: if (ok) count_nxt = count_r + CW'(1);
      OP_DELETE: if (ok) count_nxt = count_r - CW'(1);
      OP_FIND:   st_nxt = hit_r ? ST_OK : ST_NOT_FOUND;
      OP_CLEAR:  count_nxt = '0;
      default:   count_nxt = count_r;
    endcase
  end

  assign cnt_nxt_x = XW'(count_nxt);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      pos_r  <= in_position;
      word_r <= in_data_word;
    end
    if (cmd.prime) begin
      idx_r <= start_x[AW-1:0];
      end_r <= end_x[AW-1:0];
    end
    if (cmd.issue) begin
      // insert walks down, everything else walks up
      if (op_r == OP_INSERT) begin
        idx_r       <= idx_r - AW'(1);
        pend_addr_r <= idx_r + AW'(1);
      end else if (op_r == OP_DELETE) begin
        idx_r       <= idx_r + AW'(1);
        pend_addr_r <= idx_r - AW'(1);
      end else begin
        idx_r       <= idx_r + AW'(1);
        pend_addr_r <= idx_r;
      end
    end
    if (match) begin
      found_r <= pend_addr_r;
    end
    if (pend_valid_r && (op_r == OP_READ)) begin
      readv_r <= rd_data_r;
    end
    if (cmd.commit) begin
      out_status_r <= st_nxt;
      out_found_r  <= ((op_r == OP_FIND) && hit_r) ? found_x[6:0] : 7'd0;
      out_read_r   <= ((op_r == OP_READ) && ok) ? readv_r : 32'd0;
      out_count_r  <= cnt_nxt_x[7:0];
      out_empty_r  <= (count_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      hit_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= cmd.issue;
      if (cmd.prime) begin
        hit_r <= 1'b0;
      end else if (match) begin
        hit_r <= 1'b1;
      end
      if (cmd.commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_found_r;
  assign out_read_word      = out_read_r;
  assign out_entry_count    = out_count_r;
  assign out_is_empty       = out_empty_r;

endmodule

@@ rtl/ordered_array_list_engine_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_array_list_engine_core
// Ordered list of signed 32-bit words with insert, delete, find, read, clear.
// ----------------------------------------------------------------------------
// One request is handled at a time; each yields one result beat. The store is
// a memory with one read and one write port, and a walk moves one entry per
// cycle through it. A find stops at the first hit. A new request is taken
// once the previous one has committed its result, while that result may still
// wait at the output.
module ordered_array_list_engine_core
  import oal_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input logic    clk,
  input logic    rst_n,
  oal_req_if.sink   in_req,
  oal_rsp_if.source out_rsp
);

  cmd_t cmd;
  sts_t sts;

  oal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  oal_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_operation       (in_req.operation),
    .in_position        (in_req.position),
    .in_data_word       (in_req.data_word),
    .out_ready          (out_rsp.ready),
    .out_valid          (out_rsp.valid),
    .out_status         (out_rsp.status),
    .out_found_position (out_rsp.found_position),
    .out_read_word      (out_rsp.read_word),
    .out_entry_count    (out_rsp.entry_count),
    .out_is_empty       (out_rsp.is_empty)
  );

endmodule

@@ rtl/oal_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_checker
// Port-level checks of the list engine, bound to the top level.
// ----------------------------------------------------------------------------
module oal_checker
  import oal_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [6:0]  found_position,
  input logic [31:0] read_word,
  input logic [7:0]  entry_count,
  input logic        is_empty
);

  // one request at a time: no beat right after an accepted one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in work");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
    $stable(found_position) && $stable(read_word) && $stable(entry_count) &&
    $stable(is_empty))
    else $error("result beat changed while stalled");

  // a nonzero found position or read word only on success
  a_payload_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((found_position != 7'd0) || (read_word != 32'd0)) |->
    status == ST_OK)
    else $error("payload present on a failed request");

  // no result beat leaves reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ordered_array_list_engine_core oal_checker u_oal_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_req.valid),
  .in_ready       (in_req.ready),
  .out_valid      (out_rsp.valid),
  .out_ready      (out_rsp.ready),
  .status         (out_rsp.status),
  .found_position (out_rsp.found_position),
  .read_word      (out_rsp.read_word),
  .entry_count    (out_rsp.entry_count),
  .is_empty       (out_rsp.is_empty)
);

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the ordered array list engine. A directed opening covers the empty
// list, the list ends, appends, shifts, duplicates, unused codes and
// clear. Phases of random requests then grow, fill, shrink and mix the list.
// A scoreboard class holds its own copy of the list and checks every result
// beat field by field, in order.
// ----------------------------------------------------------------------------
module tb
  import oal_pkg::*;
();

  localparam int CAPACITY     = 128;
  localparam int ITEM_TARGET  = 1850;
  localparam int MAX_GAP      = 14;
  localparam int SETTLE_CYCLES = 160;
  localparam int MAX_REPORTS  = 10;

  localparam logic [2:0]         OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0]         OP_SPARE_LAST  = 3'd7;
  localparam logic signed [31:0] WORD_MIN       = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX       = 32'sh7FFF_FFFF;

  typedef enum {PH_GROW, PH_SHRINK, PH_MIXED, PH_FILL} phase_t;

  typedef struct packed {
    st_t                status;
    logic [6:0]         found_position;
    logic signed [31:0] read_word;
    logic [7:0]         entry_count;
    logic               is_empty;
  } list_result_t;

  class list_scoreboard;
    logic signed [31:0] words [CAPACITY];
    int unsigned        live;
    list_result_t       awaited [$];
    int unsigned        mismatches;
    int unsigned        results_seen;
    int unsigned        peak_count;
    int unsigned        full_rejects;
    int unsigned        range_rejects;
    int unsigned        find_hits;
    int unsigned        find_misses;
    int unsigned        op_seen [8];

    function new();
      live = 0;
    endfunction

    // Apply one accepted request to the list and queue the result it owes.
    function void note_request(logic [2:0] op, logic [6:0] pos, logic signed [31:0] word);
      list_result_t r;
      int           i;
      r        = '0;
      r.status = ST_OK;
      op_seen[op]++;
      case (op)
        OP_INSERT: begin
          if (live >= CAPACITY) begin
            r.status = ST_FULL;
            full_rejects++;
          end else if (pos > live) begin
            r.status = ST_RANGE;
            range_rejects++;
          end else begin
            for (i = live; i > pos; i--) words[i] = words[i - 1];
            words[pos] = word;
            live++;
          end
        end
        OP_DELETE: begin
          if (pos >= live) begin
            r.status = ST_RANGE;
            range_rejects++;
          end else begin
            for (i = pos; i + 1 < live; i++) words[i] = words[i + 1];
            live--;
          end
        end
        OP_FIND: begin
          r.status = ST_NOT_FOUND;
          for (i = 0; i < live; i++) begin
            if (words[i] == word) begin
              r.status         = ST_OK;
              r.found_position = 7'(i);
              break;
            end
          end
          if (r.status == ST_OK) find_hits++;
          else find_misses++;
        end
        OP_READ: begin
          if (pos >= live) begin
            r.status = ST_RANGE;
            range_rejects++;
          end else begin
            r.read_word = words[pos];
          end
        end
        OP_CLEAR: live = 0;
        default: ;
      endcase
      if (live > peak_count) peak_count = live;
      r.entry_count = 8'(live);
      r.is_empty    = (live == 0);
      awaited.push_back(r);
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result beat with nothing awaited: %s",
                   $time, $sformatf("st=%0d pos=%0d word=%0d cnt=%0d empty=%0b",
                   got.status, got.found_position, got.read_word,
                   got.entry_count, got.is_empty));
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status || got.found_position !== want.found_position ||
          got.read_word !== want.read_word || got.entry_count !== want.entry_count ||
          got.is_empty !== want.is_empty) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: result %0d differs", $time, results_seen);
          $display("  expected st=%0d pos=%0d word=%0d cnt=%0d empty=%0b",
                   want.status, want.found_position, want.read_word,
                   want.entry_count, want.is_empty);
          $display("  actual   st=%0d pos=%0d word=%0d cnt=%0d empty=%0b",
                   got.status, got.found_position, got.read_word,
                   got.entry_count, got.is_empty);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  oal_req_if in_req ();
  oal_rsp_if out_rsp ();

  ordered_array_list_engine_core #(.CAPACITY(CAPACITY)) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  list_scoreboard board;
  bit             sender_idles;
  bit             receiver_idles;
  int unsigned    items_sent;
  int unsigned    drains;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_request(input logic [2:0] op, input logic [6:0] pos,
                              input logic signed [31:0] word);
    int unsigned gap;
    gap = sender_idles ? $urandom_range(0, MAX_GAP) : 0;
    // Keep valid high across back-to-back beats.
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid     <= 1'b1;
    in_req.operation <= op;
    in_req.position  <= pos;
    in_req.data_word <= word;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    board.note_request(op, pos, word);
    if (op <= OP_CLEAR) items_sent++;
  endtask

  // Hold the sender until every owed result has come back.
  task automatic drain_results();
    in_req.valid <= 1'b0;
    @(posedge clk);
    while (board.awaited.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_word();
    int unsigned r;
    int          near_zero;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom;
    if (r < 85) begin
      near_zero = $urandom_range(0, 8);
      return near_zero - 4;
    end
    case ($urandom_range(0, 3))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_find_word();
    if (board.live > 0 && $urandom_range(0, 99) < 70)
      return board.words[$urandom_range(0, board.live - 1)];
    return pick_word();
  endfunction

  // Mostly positions below limit, with ends, one-past-end and wild values mixed in.
  function automatic logic [6:0] pick_pos(int unsigned limit);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (limit == 0 || r < 8) return 7'($urandom_range(0, CAPACITY - 1));
    if (r < 14 && limit < CAPACITY) return 7'(limit);
    if (r < 22) return '0;
    if (r < 32) return 7'(limit - 1);
    return 7'($urandom_range(0, limit - 1));
  endfunction

  function automatic logic [2:0] pick_op(phase_t kind);
    int unsigned cut [5];
    int unsigned r;
    case (kind)
      PH_GROW:   cut = '{60, 70, 84, 98, 98};
      PH_SHRINK: cut = '{12, 70, 84, 98, 98};
      PH_FILL:   cut = '{85, 88, 94, 100, 100};
      default:   cut = '{35, 65, 81, 97, 98};
    endcase
    r = $urandom_range(0, 99);
    if (r < cut[0]) return OP_INSERT;
    if (r < cut[1]) return OP_DELETE;
    if (r < cut[2]) return OP_FIND;
    if (r < cut[3]) return OP_READ;
    if (r < cut[4]) return OP_CLEAR;
    return 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
  endfunction

  // A fill phase runs until the list is full and then length beats more.
  task automatic run_phase(input phase_t kind, input int unsigned length);
    int unsigned        done_items;
    logic [2:0]         op;
    logic [6:0]         pos;
    logic signed [31:0] word;
    done_items = 0;
    while (done_items < length || (kind == PH_FILL && board.live < CAPACITY)) begin
      if (kind != PH_FILL && items_sent >= ITEM_TARGET) break;
      op = pick_op(kind);
      case (op)
        OP_INSERT: begin
          pos  = pick_pos(board.live < CAPACITY ? board.live + 1 : CAPACITY);
          word = pick_word();
        end
        OP_DELETE, OP_READ: begin
          pos  = pick_pos(board.live);
          word = $urandom;
        end
        OP_FIND: begin
          pos  = 7'($urandom);
          word = pick_find_word();
        end
        default: begin
          pos  = 7'($urandom);
          word = $urandom;
        end
      endcase
      send_request(op, pos, word);
      if (kind != PH_FILL || board.live == CAPACITY) done_items++;
    end
  endtask

  initial begin : result_sink
    list_result_t got;
    int unsigned  stall;
    int unsigned  left;
    out_rsp.ready = 1'b0;
    left          = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (left == 0) begin
        receiver_idles = ($urandom_range(0, 2) != 0);
        left           = $urandom_range(20, 80);
      end
      left--;
      stall = receiver_idles ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        out_rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_rsp.ready <= 1'b1;
      @(posedge clk);
      while (!out_rsp.valid) @(posedge clk);
      got.status         = st_t'(out_rsp.status);
      got.found_position = out_rsp.found_position;
      got.read_word      = out_rsp.read_word;
      got.entry_count    = out_rsp.entry_count;
      got.is_empty       = out_rsp.is_empty;
      board.check_result(got);
    end
  end

  initial begin : stimulus
    int unsigned phase_no;
    phase_t      kind;
    rst_n            = 1'b0;
    in_req.valid     = 1'b0;
    in_req.operation = OP_CLEAR;
    in_req.position  = '0;
    in_req.data_word = '0;
    board            = new();
    items_sent       = 0;
    drains           = 0;
    sender_idles     = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list: every position is out of range and nothing is found.
    send_request(OP_READ,   7'd0,   32'sd0);
    send_request(OP_DELETE, 7'd0,   32'sd0);
    send_request(OP_FIND,   7'd0,   32'sd5);
    send_request(OP_INSERT, 7'd1,   32'sd9);
    // Build 0, -1, MIN, MAX through appends and front/middle inserts.
    send_request(OP_INSERT, 7'd0,   WORD_MIN);
    send_request(OP_INSERT, 7'd1,   WORD_MAX);
    send_request(OP_INSERT, 7'd0,   32'sd0);
    send_request(OP_INSERT, 7'd1,   -32'sd1);
    send_request(OP_FIND,   7'd127, WORD_MAX);
    send_request(OP_FIND,   7'd0,   32'sd12345);
    send_request(OP_READ,   7'd3,   '1);
    send_request(OP_READ,   7'd127, '1);
    send_request(OP_INSERT, 7'd127, '1);
    send_request(OP_DELETE, 7'd4,   '0);
    send_request(OP_DELETE, 7'd1,   '0);
    send_request(OP_DELETE, 7'd2,   '0);
    for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++)
      send_request(3'(c), 7'($urandom), $urandom);
    // Duplicate value: find must report the first copy.
    send_request(OP_INSERT, 7'd2,   32'sd0);
    send_request(OP_FIND,   7'd0,   32'sd0);
    send_request(OP_CLEAR,  7'd0,   '0);
    send_request(OP_READ,   7'd0,   '0);
    send_request(OP_FIND,   7'd0,   32'sd0);

    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase_no == 1 || $urandom_range(0, 2) == 0) begin
        drain_results();
        drains++;
      end
      sender_idles = ($urandom_range(0, 3) != 0);
      case (phase_no)
        0:       kind = PH_GROW;
        1:       kind = PH_FILL;
        2:       kind = PH_SHRINK;
        default: kind = phase_t'($urandom_range(0, 3));
      endcase
      run_phase(kind, kind == PH_FILL ? 30 : $urandom_range(40, 120));
      phase_no++;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d requests over %0d phases: insert %0d, delete %0d,",
             items_sent, phase_no, board.op_seen[OP_INSERT], board.op_seen[OP_DELETE]);
    $display("  find %0d, read %0d, clear %0d, unused codes %0d.",
             board.op_seen[OP_FIND], board.op_seen[OP_READ], board.op_seen[OP_CLEAR],
             board.op_seen[OP_SPARE_FIRST] + board.op_seen[OP_SPARE_FIRST + 1] +
             board.op_seen[OP_SPARE_LAST]);
    $display("Peak count %0d, full rejects %0d, range rejects %0d, find hits %0d / misses %0d,",
             board.peak_count, board.full_rejects, board.range_rejects, board.find_hits,
             board.find_misses);
    $display("  %0d drains, %0d results, %0d mismatches.",
             drains, board.results_seen, board.mismatches);
    if (board.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("Run timed out with %0d results still owed.", board.awaited.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
